// ----- sv/tsc_pkg.sv -----
package tsc_pkg;

    // frame layout
    localparam int unsigned FrameLastIndex = 8;
    localparam int unsigned CountWidth     = 4;
    localparam logic [7:0]  CrcPoly        = 8'h8C;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_BAD_CRC  = 2'd1,
        STATUS_ALL_ZERO = 2'd2
    } t_status;

    // one result as it travels from the frame logic to the output register
    typedef struct packed {
        t_status            status;
        logic signed [15:0] temperature;
    } t_result;

    // reflected crc-8, one byte, lsb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b_in);
        logic [7:0] crc;
        logic [7:0] b;
        logic       mix;
        crc = crc_in;
        b   = b_in;
        for (int k = 0; k < 8; k++) begin
            mix = crc[0] ^ b[0];
            crc = {1'b0, crc[7:1]};
            if (mix) begin
                crc = crc ^ CrcPoly;
            end
            b = {1'b0, b[7:1]};
        end
        return crc;
    endfunction

endpackage

// ----- sv/tsc_if.sv -----
// byte channel into the checker
interface tsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// result channel out of the checker
interface tsc_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [15:0] temperature;

    modport source (output valid, output status, output temperature, input ready);
    modport sink   (input valid, input status, input temperature, output ready);
endinterface

// ----- sv/tsc_frame.sv -----
module tsc_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_result_valid,
    output tsc_pkg::t_result  o_result
);

    logic [tsc_pkg::CountWidth-1:0] r_count;
    logic [tsc_pkg::CountWidth-1:0] n_count;
    logic [7:0]                     r_crc;
    logic [7:0]                     n_crc;
    logic                           r_seen;
    logic                           n_seen;
    logic [15:0]                    r_temp;
    logic [15:0]                    n_temp;
    logic                           is_last;
    logic                           seen_now;

    // any count of eight or more closes the frame
    assign is_last  = (r_count >= tsc_pkg::CountWidth'(tsc_pkg::FrameLastIndex));
    assign seen_now = r_seen | (i_byte != 8'd0);
    assign o_take   = i_valid && (!is_last || i_out_free);
    assign o_result_valid = o_take && is_last;

    // check on the ninth byte, crc first
    always_comb begin
        if (r_crc != i_byte) begin
            o_result.status      = tsc_pkg::STATUS_BAD_CRC;
            o_result.temperature = '0;
        end else if (!seen_now) begin
            o_result.status      = tsc_pkg::STATUS_ALL_ZERO;
            o_result.temperature = '0;
        end else begin
            o_result.status      = tsc_pkg::STATUS_GOOD;
            o_result.temperature = r_temp;
        end
    end

    // next frame state
    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        n_seen  = r_seen;
        n_temp  = r_temp;
        if (o_take) begin
            if (is_last) begin
                n_count = '0;
                n_crc   = '0;
                n_seen  = 1'b0;
            end else begin
                n_count = r_count + 1'b1;
                n_crc   = tsc_pkg::crc8_byte(r_crc, i_byte);
                n_seen  = seen_now;
                if (r_count == '0) begin
                    n_temp = {r_temp[15:8], i_byte};
                end else if (r_count == tsc_pkg::CountWidth'(1)) begin
                    n_temp = {i_byte, r_temp[7:0]};
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= '0;
            r_seen  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
            r_seen  <= n_seen;
        end
    end

    // captured temperature word
    always_ff @(posedge i_clk) begin
        r_temp <= n_temp;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tsc_pkg::CountWidth'(tsc_pkg::FrameLastIndex))
        else $error("byte counter out of range");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && is_last |=> (r_count == '0) && (r_crc == 8'd0) && !r_seen)
        else $error("frame state not cleared after ninth byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && !is_last |=> r_count == $past(r_count) + 1'b1)
        else $error("byte counter did not advance");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |=> $stable(r_count) && $stable(r_crc))
        else $error("frame state changed without a byte");

endmodule

// ----- sv/tsc_out_reg.sv -----
module tsc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tsc_pkg::t_result  i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output tsc_pkg::t_result  o_result
);

    logic             r_valid;
    logic             n_valid;
    tsc_pkg::t_result r_result;

    // register is free when empty or being emptied
    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- sv/thermometer_scratchpad_checker_core.sv -----
// Scratchpad checker: takes the nine scratchpad bytes of a one-wire
// thermometer, one request per byte, and gives one result on the ninth byte
// with a status (good, crc mismatch, all zero) and the raw signed Q12.4
// temperature, zero unless the status is good. A byte is taken every cycle
// while the frame logic is not stalled; it is held in the input register,
// folded into the frame state by the byte-wide crc step, and its result (if
// any) is loaded into the output register when the frame logic takes it.
// A stalled result register blocks only the ninth byte of the next frame;
// the ready chain from the result side to the byte side is combinational.
module thermometer_scratchpad_checker_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tsc_byte_if.sink            i_byte,
    tsc_result_if.source        o_result
);

    logic             r_in_valid;
    logic             n_in_valid;
    logic [7:0]       r_in_byte;
    logic             take;
    logic             out_free;
    logic             res_valid;
    tsc_pkg::t_result res;
    tsc_pkg::t_result out_res;

    // input register
    assign i_byte.ready = !r_in_valid || take;
    assign n_in_valid   = i_byte.valid || (r_in_valid && !take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
        end
    end

    // frame tracking and check
    tsc_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_in_valid),
        .i_byte         (r_in_byte),
        .i_out_free     (out_free),
        .o_take         (take),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    // result register
    tsc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (res),
        .i_ready  (o_result.ready),
        .o_free   (out_free),
        .o_valid  (o_result.valid),
        .o_result (out_res)
    );

    assign o_result.status      = out_res.status;
    assign o_result.temperature = out_res.temperature;

endmodule

// ----- tb/scratchpad_frame_monitor.sv -----
`timescale 1ns / 1ps

// watches both channels of the scratchpad checker, predicts the verdict of
// every frame and compares it with what comes out of the result channel
module scratchpad_frame_monitor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_valid,
    input  logic               i_byte_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [1:0]         i_status,
    input  logic signed [15:0] i_temperature,
    output int                 o_fail_count,
    output int                 o_pending
);

    // frame state as seen by the predictor
    logic [3:0]  byte_index;
    logic [7:0]  crc_run;
    logic        any_nonzero;
    logic [15:0] temp_capture;

    tsc_pkg::t_result verdicts_due[$];
    int               mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    // reflected crc step, whole byte folded in at once
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        acc = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            acc = acc[0] ? ((acc >> 1) ^ tsc_pkg::CrcPoly) : (acc >> 1);
        end
        return acc;
    endfunction

    // advance the frame by one byte; the ninth byte queues a verdict
    task automatic fold_scratchpad_byte(input logic [7:0] b);
        tsc_pkg::t_result v;
        if (b != 8'd0) begin
            any_nonzero = 1'b1;
        end
        if (byte_index < tsc_pkg::FrameLastIndex) begin
            crc_run = crc_fold(crc_run, b);
            if (byte_index == 4'd0) begin
                temp_capture[7:0] = b;
            end else if (byte_index == 4'd1) begin
                temp_capture[15:8] = b;
            end
            byte_index = byte_index + 4'd1;
        end else begin
            // crc check wins over the all-zero check
            if (crc_run != b) begin
                v = '{status: tsc_pkg::STATUS_BAD_CRC, temperature: 16'sd0};
            end else if (!any_nonzero) begin
                v = '{status: tsc_pkg::STATUS_ALL_ZERO, temperature: 16'sd0};
            end else begin
                v = '{status: tsc_pkg::STATUS_GOOD, temperature: temp_capture};
            end
            verdicts_due.push_back(v);
            byte_index  = 4'd0;
            crc_run     = 8'd0;
            any_nonzero = 1'b0;
        end
    endtask

    // results first: a result never belongs to a byte of the same edge
    always @(posedge i_clk) begin : watch
        tsc_pkg::t_result want;
        if (!i_rst_n) begin
            byte_index  = 4'd0;
            crc_run     = 8'd0;
            any_nonzero = 1'b0;
            verdicts_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result with no frame pending: status %0d, temperature %0d",
                           i_status, i_temperature);
                    mismatch_total++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        mismatch_total++;
                    end
                    if (i_temperature !== want.temperature) begin
                        $error("temperature mismatch: expected %0d, actual %0d",
                               want.temperature, i_temperature);
                        mismatch_total++;
                    end
                end
            end
            if (i_byte_valid && i_byte_ready) begin
                fold_scratchpad_byte(i_data_byte);
            end
        end
        o_pending <= verdicts_due.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_verdicts;

    tsc_byte_if   byte_ch ();
    tsc_result_if result_ch ();

    thermometer_scratchpad_checker_core DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    scratchpad_frame_monitor u_monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_byte_valid  (byte_ch.valid),
        .i_byte_ready  (byte_ch.ready),
        .i_data_byte   (byte_ch.data_byte),
        .i_res_valid   (result_ch.valid),
        .i_res_ready   (result_ch.ready),
        .i_status      (result_ch.status),
        .i_temperature (result_ch.temperature),
        .o_fail_count  (fail_count),
        .o_pending     (pending_verdicts)
    );

    // 2 ns clock
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    logic [7:0] frame_bytes [0:8];
    int         burst_left = 0;
    int         bytes_sent = 0;

    // crc over bytes 0..7 of the frame being built
    function automatic logic [7:0] frame_crc();
        logic [7:0] acc;
        acc = 8'd0;
        for (int n = 0; n < 8; n++) begin
            acc = acc ^ frame_bytes[n];
            for (int i = 0; i < 8; i++) begin
                acc = acc[0] ? ((acc >> 1) ^ 8'h8C) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    // one byte request; called and returns at a falling edge
    task automatic offer_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        do @(posedge clk); while (!byte_ch.ready);
        @(negedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int n = 0; n < 9; n++) begin
            offer_byte(frame_bytes[n]);
        end
    endtask

    // hold the byte side until every queued verdict has come out
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_verdicts != 0);
        burst_left = $urandom_range(1, 40);
    endtask

    // random temperature byte, leaning on the sign and range extremes
    function automatic logic [7:0] temp_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // fill frame_bytes with one frame of the chosen shape
    task automatic build_random_frame();
        int kind;
        int spot;
        kind = $urandom_range(0, 99);
        frame_bytes[0] = temp_byte();
        frame_bytes[1] = temp_byte();
        for (int n = 2; n < 8; n++) begin
            frame_bytes[n] = 8'($urandom_range(0, 255));
        end
        if (kind < 60) begin
            // well-formed frame
            frame_bytes[8] = frame_crc();
        end else if (kind < 72) begin
            // corrupted crc byte
            frame_bytes[8] = frame_crc() ^ 8'($urandom_range(1, 255));
        end else if (kind < 78) begin
            // all nine bytes zero
            for (int n = 0; n < 9; n++) begin
                frame_bytes[n] = 8'd0;
            end
        end else if (kind < 84) begin
            // zero body with a nonzero crc byte
            for (int n = 0; n < 8; n++) begin
                frame_bytes[n] = 8'd0;
            end
            frame_bytes[8] = 8'($urandom_range(1, 255));
        end else if (kind < 92) begin
            // single nonzero byte somewhere in an otherwise zero frame
            for (int n = 0; n < 8; n++) begin
                frame_bytes[n] = 8'd0;
            end
            spot = $urandom_range(0, 7);
            frame_bytes[spot] = 8'($urandom_range(1, 255));
            frame_bytes[8] = frame_crc();
        end else begin
            // noise
            frame_bytes[8] = 8'($urandom_range(0, 255));
        end
    endtask

    // result side: stall patterns, with a long hold-off now and then
    initial begin : result_sink
        int rx_cycles;
        int next_hold;
        int seg;
        int mode;
        result_ch.ready = 1'b0;
        rx_cycles = 0;
        next_hold = 300;
        wait (rst_n);
        forever begin
            if (rx_cycles >= next_hold) begin
                @(negedge clk);
                result_ch.ready <= 1'b0;
                repeat (150) @(negedge clk);
                rx_cycles += 151;
                next_hold += 1800;
            end
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(5, 60);
            repeat (seg) begin
                @(negedge clk);
                rx_cycles++;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: result_ch.ready <= ((rx_cycles % 5) < 3);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial begin
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'd0;
        rst_n             = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // all zero frame
        for (int n = 0; n < 9; n++) begin
            frame_bytes[n] = 8'd0;
        end
        send_frame();
        // all ones body with matching crc: good, temperature -1
        for (int n = 0; n < 8; n++) begin
            frame_bytes[n] = 8'hFF;
        end
        frame_bytes[8] = frame_crc();
        send_frame();
        // most negative temperature under a broken crc
        frame_bytes[0] = 8'h00;
        frame_bytes[1] = 8'h80;
        for (int n = 2; n < 8; n++) begin
            frame_bytes[n] = 8'h55 << (n % 2);
        end
        frame_bytes[8] = ~frame_crc();
        send_frame();
        wait_drained();

        // random frames, with one full drain half way through
        while (bytes_sent < 1000) begin
            build_random_frame();
            send_frame();
            if (bytes_sent >= 500 && bytes_sent < 509) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("PASS thermometer_scratchpad_checker_core");
        end else begin
            $display("FAIL thermometer_scratchpad_checker_core");
        end
        $finish;
    end

    // run limit
    initial begin
        #400000;
        $display("FAIL thermometer_scratchpad_checker_core");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/tsc_pkg.sv
sv/tsc_if.sv
sv/tsc_frame.sv
sv/tsc_out_reg.sv
sv/thermometer_scratchpad_checker_core.sv
tb/scratchpad_frame_monitor.sv
tb/tb_top.sv
